[src/tpcd_pkg.sv]
// Shared types and constants for the tracker pattern chunk decoder.
`timescale 1ns / 1ps
package tpcd_pkg;

  localparam int EffectSlots = 4;
  localparam int Channels    = 32;
  localparam int ChanW       = $clog2(Channels);
  localparam int QueueDepth  = 4;

  // configuration register indexes
  localparam logic [1:0] CFG_NOTE_OFFSET   = 2'd0;
  localparam logic [1:0] CFG_KEYOFF_ENABLE = 2'd1;
  localparam logic [1:0] CFG_ROW_COUNT     = 2'd2;

  // event kinds
  localparam logic [3:0] EV_EMPTY_ROW  = 4'd0;
  localparam logic [3:0] EV_NOTE       = 4'd1;
  localparam logic [3:0] EV_KEYOFF     = 4'd2;
  localparam logic [3:0] EV_INSTRUMENT = 4'd3;
  localparam logic [3:0] EV_VOLUME     = 4'd4;
  localparam logic [3:0] EV_PAN        = 4'd5;
  localparam logic [3:0] EV_DELAY      = 4'd6;
  localparam logic [3:0] EV_EFFECT     = 4'd7;
  localparam logic [3:0] EV_DROPPED    = 4'd8;
  localparam logic [3:0] EV_NONE       = 4'd9;

  // command numbers handled specially
  localparam logic [5:0] CMD_TONE_PORTA = 6'h03;
  localparam logic [5:0] CMD_PORTA_VOL  = 6'h05;
  localparam logic [5:0] CMD_FINE_PORTA = 6'h15;
  localparam logic [5:0] CMD_PAN        = 6'h08;
  localparam logic [5:0] CMD_VOLUME     = 6'h0c;
  localparam logic [5:0] CMD_EXTENDED   = 6'h0e;

  // byte classification made by the front end
  typedef struct packed {
    logic       is_empty_row; // 0xff
    logic       has_note;     // low 7 bits nonzero
    logic       is_zero;      // whole byte zero
    logic       hi_nib_zero;  // upper nibble 0 (pan)
    logic       hi_nib_d;     // upper nibble 0xd (delay note)
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        start;
    byte_class_t cls;
  } item_t;

  typedef struct packed {
    logic [6:0] note_offset;
    logic       keyoff_enable;
    logic [8:0] row_count;
  } cfg_t;

  typedef struct packed {
    logic       pattern_done;
    logic       truncated;
    logic       portamento;
    logic [2:0] effect_slot;
    logic [5:0] command;
    logic [7:0] value;
    logic [7:0] row;
    logic [4:0] channel;
    logic [3:0] event_kind;
  } result_t;

endpackage

[src/tpcd_front.sv]
// Front end: input register and byte classification.
`timescale 1ns / 1ps
module tpcd_front import tpcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data,
  input  logic       in_last,
  input  logic       in_start,
  output logic       push,
  output item_t      push_item,
  input  logic       queue_full
);

  logic  held;
  item_t item;

  assign push      = held && !queue_full;
  assign in_ready  = !held || !queue_full;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.data             <= in_data;
      item.last             <= in_last;
      item.start            <= in_start;
      item.cls.is_empty_row <= (in_data == 8'hff);
      item.cls.has_note     <= (in_data[6:0] != 7'd0);
      item.cls.is_zero      <= (in_data == 8'h00);
      item.cls.hi_nib_zero  <= (in_data[7:4] == 4'h0);
      item.cls.hi_nib_d     <= (in_data[7:4] == 4'hd);
    end
  end

endmodule

[src/tpcd_queue.sv]
// Short queue between the front end and the parser.
`timescale 1ns / 1ps
module tpcd_queue import tpcd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head_item
);

  localparam int PtrW = $clog2(QueueDepth);

  item_t           slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;

  assign full      = (count == (PtrW + 1)'(QueueDepth));
  assign not_empty = (count != '0);
  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

[src/tpcd_back.sv]
// Back end: chunk parser, row and effect tracking, output register.
`timescale 1ns / 1ps
module tpcd_back import tpcd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    item_valid,
  input  item_t   item,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  localparam logic [2:0] PH_HEAD       = 3'd0;
  localparam logic [2:0] PH_NOTE       = 3'd1;
  localparam logic [2:0] PH_INST_END   = 3'd2;
  localparam logic [2:0] PH_INST_CMD   = 3'd3;
  localparam logic [2:0] PH_CMD        = 3'd4;
  localparam logic [2:0] PH_PARAM_END  = 3'd5;
  localparam logic [2:0] PH_PARAM_MORE = 3'd6;

  logic [2:0]       phase, phase_next;
  logic [ChanW-1:0] chan, chan_next;
  logic [8:0]       row_pos, row_pos_next;
  logic             last_on_row, last_on_row_next;
  logic [5:0]       pend_cmd, pend_cmd_next;
  logic             finished, finished_next;
  logic [2:0]       fx_count [Channels];

  logic             produce;
  result_t          res;
  logic             fx_inc;
  logic             row_adv;
  logic [2:0]       fx_cur;
  logic [2:0]       ph_e;
  logic [8:0]       rp_e;
  logic             lor_e;
  logic [5:0]       pc_e;
  logic [7:0]       b;

  assign pop = item_valid && (!out_valid || out_ready);
  assign b   = item.data;

  always_comb begin
    // start of pattern clears before the byte is taken
    ph_e   = item.start ? PH_HEAD : phase;
    rp_e   = item.start ? 9'd0 : row_pos;
    lor_e  = item.start ? 1'b0 : last_on_row;
    pc_e   = item.start ? 6'd0 : pend_cmd;
    fx_cur = item.start ? 3'd0 : fx_count[chan];

    phase_next       = ph_e;
    chan_next        = chan;
    row_pos_next     = rp_e;
    last_on_row_next = lor_e;
    pend_cmd_next    = pc_e;
    finished_next    = item.start ? 1'b0 : finished;
    produce          = 1'b0;
    fx_inc           = 1'b0;
    row_adv          = 1'b0;
    res              = '0;
    res.event_kind   = EV_NONE;
    res.row          = rp_e[7:0];

    if (finished_next || rp_e >= cfg.row_count) begin
      finished_next = 1'b1;
    end else begin
      produce = 1'b1;
      case (ph_e)
        PH_HEAD: begin
          if (item.cls.is_empty_row) begin
            res.event_kind = EV_EMPTY_ROW;
            chan_next      = '0;
            row_adv        = 1'b1;
          end else begin
            chan_next        = b[4:0];
            last_on_row_next = b[7];
            phase_next       = b[6] ? PH_CMD : PH_NOTE;
          end
        end
        PH_NOTE: begin
          if (item.cls.has_note) begin
            if (cfg.keyoff_enable && b[6:0] == 7'd1) begin
              res.event_kind = EV_KEYOFF;
            end else begin
              res.event_kind = EV_NOTE;
              res.value      = {1'b0, b[6:0]} + {1'b0, cfg.note_offset};
            end
          end
          phase_next = b[7] ? PH_INST_CMD : PH_INST_END;
        end
        PH_INST_END, PH_INST_CMD: begin
          if (!item.cls.is_zero) begin
            res.event_kind = EV_INSTRUMENT;
            res.value      = b - 8'd1;
          end
          if (ph_e == PH_INST_CMD) begin
            phase_next = PH_CMD;
          end else begin
            phase_next = PH_HEAD;
            row_adv    = lor_e;
          end
        end
        PH_CMD: begin
          if (b[6]) begin
            res.event_kind = EV_VOLUME;
            res.value      = {b[5:0], 1'b0};
            if (b[7]) begin
              phase_next = PH_CMD;
            end else begin
              phase_next = PH_HEAD;
              row_adv    = lor_e;
            end
          end else begin
            pend_cmd_next = b[5:0];
            phase_next    = b[7] ? PH_PARAM_MORE : PH_PARAM_END;
          end
        end
        default: begin
          // parameter byte of a pending command
          if (pc_e == CMD_PAN && item.cls.hi_nib_zero) begin
            res.event_kind = EV_PAN;
            res.value      = b;
          end else if (pc_e == CMD_VOLUME) begin
            res.event_kind = EV_VOLUME;
            res.value      = b;
          end else if (pc_e == CMD_EXTENDED && item.cls.hi_nib_d) begin
            res.event_kind = EV_DELAY;
            res.value      = {4'h0, b[3:0]};
          end else begin
            res.command = pc_e;
            res.value   = b;
            if (fx_cur < 3'(EffectSlots)) begin
              res.event_kind  = EV_EFFECT;
              res.effect_slot = fx_cur;
              fx_inc          = 1'b1;
            end else begin
              res.event_kind = EV_DROPPED;
            end
            res.portamento = (pc_e == CMD_TONE_PORTA) || (pc_e == CMD_PORTA_VOL) ||
                             (pc_e == CMD_FINE_PORTA);
          end
          if (ph_e == PH_PARAM_MORE) begin
            phase_next = PH_CMD;
          end else begin
            phase_next = PH_HEAD;
            row_adv    = lor_e;
          end
        end
      endcase

      if (row_adv) begin
        row_pos_next = rp_e + 9'd1;
      end
      res.channel = (res.event_kind == EV_EMPTY_ROW) ? 5'd0 : chan_next;
      if (item.last) begin
        if (phase_next != PH_HEAD) begin
          res.truncated = 1'b1;
          phase_next    = PH_HEAD;
        end
        finished_next = 1'b1;
      end
      if (row_pos_next >= cfg.row_count) begin
        finished_next    = 1'b1;
        res.pattern_done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEAD;
      chan        <= '0;
      row_pos     <= '0;
      last_on_row <= 1'b0;
      pend_cmd    <= '0;
      finished    <= 1'b0;
      out_valid   <= 1'b0;
      for (int i = 0; i < Channels; i++) begin
        fx_count[i] <= '0;
      end
    end else begin
      if (pop) begin
        phase       <= phase_next;
        chan        <= chan_next;
        row_pos     <= row_pos_next;
        last_on_row <= last_on_row_next;
        pend_cmd    <= pend_cmd_next;
        finished    <= finished_next;
        out_valid   <= produce;
        for (int i = 0; i < Channels; i++) begin
          if (row_adv) begin
            fx_count[i] <= '0;
          end else if (fx_inc && chan == ChanW'(i)) begin
            fx_count[i] <= fx_cur + 3'd1;
          end else if (item.start) begin
            fx_count[i] <= '0;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_result <= res;
    end
  end

endmodule

[src/tracker_pattern_chunk_decoder_top.sv]
// Top level of the tracker pattern chunk decoder.
`timescale 1ns / 1ps
// Decodes packed tracker pattern data, one byte per input transaction.
// Input stream (s_*): tdata carries the pattern byte, tlast marks the final
// byte of the buffer, tuser set clears row, parse state, effect counts and
// the finished flag before the byte is taken.
// Output stream (m_*): one decoded event per byte that is not ignored;
// bytes after the buffer end or past the last row give no transaction.
// Config port: cfg_we writes cfg_data into register cfg_index
// (0 note offset, 1 key-off enable, 2 row count); write only while idle.
// Path from input transaction to output valid: input register (loads on
// the accepting edge), queue slot write, parser output register.
// Throughput: one byte per cycle while the output is not stalled; the
// parser retires one queue entry per cycle when m_tready allows, and its
// state loop (phase, row, per-channel effect count) is combinational.
// Reset: rst clears parse state, row, counts, queue and restores register
// defaults (offset 24, key-off on, 64 rows).
// Stall: when m_tready is low the result register holds; the 4-entry queue
// and input register keep taking bytes until full, then s_tready drops.
module tracker_pattern_chunk_decoder_top import tpcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // data_byte[7:0]
  input  logic        s_tlast,
  input  logic        s_tuser,  // start_pattern
  output logic        m_tvalid,
  input  logic        m_tready,
  // event_kind[3:0], channel[8:4], row[16:9], value[24:17], command[30:25],
  // effect_slot[33:31], portamento[34], truncated[35], pattern_done[36], zero pad
  output logic [39:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  cfg_t    cfg;
  logic    push, full, pop, q_valid;
  item_t   push_item, head_item;
  result_t result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.note_offset   <= 7'd24;
      cfg.keyoff_enable <= 1'b1;
      cfg.row_count     <= 9'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NOTE_OFFSET:   cfg.note_offset   <= cfg_data[6:0];
        CFG_KEYOFF_ENABLE: cfg.keyoff_enable <= cfg_data[0];
        CFG_ROW_COUNT:     cfg.row_count     <= cfg_data;
        default: ;
      endcase
    end
  end

  tpcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_data    (s_tdata),
    .in_last    (s_tlast),
    .in_start   (s_tuser),
    .push       (push),
    .push_item  (push_item),
    .queue_full (full)
  );

  tpcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .not_empty (q_valid),
    .head_item (head_item)
  );

  tpcd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (q_valid),
    .item       (head_item),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  assign m_tdata = {3'b000, result};

endmodule

[sim/tracker_pattern_chunk_decoder_top_tb.sv]
// Self-checking testbench for the tracker pattern chunk decoder.
`timescale 1ns / 1ps
// Drives packed pattern bytes into the decoder over the input stream and
// checks every decoded event on the output stream against a behavioral
// model held in a small scoreboard class.
//
// Flow:
//  - a directed run at the reset register values walks one chunk through
//    every command path: empty row, note with key-off and offset, zero and
//    nonzero instrument, volume/2, pan, volume, delay note, the three
//    portamento commands, a dropped effect past the slot limit, a row
//    advance and a buffer that ends inside a chunk;
//  - random phases follow, each with its own register setting (row counts
//    1 and 256, note offsets 0 and 127, key-off on and off among them).
//    Most stimulus is well-formed chunks with random content; some patterns
//    are plain noise, some end mid-chunk, some are cut by a new pattern
//    start, and some get trailing bytes the block must ignore.
//  - registers change only with the block idle: all expected events in,
//    then a settling wait so ignored bytes leave the pipeline.
//  - both sides draw a random gap per transaction, with whole phases
//    at full rate; once in a while the sink holds off long enough that
//    the internal queue fills and input backpressure shows up.
// A watchdog ends the run when no transaction moves for too long.
module tracker_pattern_chunk_decoder_top_tb;
  import tpcd_pkg::*;

  localparam int IdleLimit     = 1000; // cycles without any transaction
  localparam int HoldOffCycles = 80;   // long sink stall, fills the queue
  localparam int SettleCycles  = 12;   // pipeline depth plus margin

  // parser position inside a chunk
  typedef enum logic [2:0] {
    ST_HEAD,
    ST_NOTE,
    ST_INST_END,
    ST_INST_CMD,
    ST_CMD,
    ST_PARAM_END,
    ST_PARAM_MORE
  } chunk_state_t;

  // Behavioral model of the decoder plus the queue of events it predicts.
  class pattern_event_scoreboard;
    logic [6:0]   note_offset;
    logic         keyoff_en;
    logic [8:0]   row_count;
    chunk_state_t state;
    logic [4:0]   chan;
    logic [8:0]   row_pos;
    logic         last_on_row;
    logic [5:0]   pend_cmd;
    logic [2:0]   fx_count [Channels];
    logic         done;
    result_t      expected_events [$];
    int           errors;

    function new();
      note_offset = 7'd24;
      keyoff_en   = 1'b1;
      row_count   = 9'd64;
      state       = ST_HEAD;
      chan        = '0;
      row_pos     = '0;
      last_on_row = 1'b0;
      pend_cmd    = '0;
      done        = 1'b0;
      errors      = 0;
      clear_counts();
    endfunction

    function void clear_counts();
      foreach (fx_count[i]) fx_count[i] = '0;
    endfunction

    function void advance_row();
      row_pos = row_pos + 9'd1;
      clear_counts();
    endfunction

    function void end_chunk();
      if (last_on_row) advance_row();
      state = ST_HEAD;
    endfunction

    function void write_reg(logic [1:0] idx, logic [8:0] data);
      case (idx)
        CFG_NOTE_OFFSET:   note_offset = data[6:0];
        CFG_KEYOFF_ENABLE: keyoff_en   = data[0];
        CFG_ROW_COUNT:     row_count   = data;
        default: ;
      endcase
    endfunction

    // Advance the model by one accepted byte; returns 1 when an event is due.
    function bit take_byte(logic [7:0] b, logic last, logic start);
      result_t r;
      logic [5:0] c;
      logic       more;
      r = '0;
      r.event_kind = EV_NONE;
      if (start) begin
        row_pos     = '0;
        state       = ST_HEAD;
        last_on_row = 1'b0;
        pend_cmd    = '0;
        done        = 1'b0;
        clear_counts();
      end
      // past the buffer end or the last row: byte is dropped silently
      if (done || row_pos >= row_count) begin
        done = 1'b1;
        return 0;
      end
      r.row = row_pos[7:0];
      case (state)
        ST_HEAD: begin
          if (b == 8'hff) begin
            r.event_kind = EV_EMPTY_ROW;
            chan = '0;
            advance_row();
          end else begin
            chan        = b[4:0];
            last_on_row = b[7];
            state       = b[6] ? ST_CMD : ST_NOTE;
          end
        end
        ST_NOTE: begin
          if (b[6:0] != 7'd0) begin
            if (keyoff_en && b[6:0] == 7'd1) begin
              r.event_kind = EV_KEYOFF;
            end else begin
              r.event_kind = EV_NOTE;
              r.value      = {1'b0, b[6:0]} + {1'b0, note_offset};
            end
          end
          state = b[7] ? ST_INST_CMD : ST_INST_END;
        end
        ST_INST_END, ST_INST_CMD: begin
          // zero means no instrument given
          if (b != 8'd0) begin
            r.event_kind = EV_INSTRUMENT;
            r.value      = b - 8'd1;
          end
          if (state == ST_INST_CMD) state = ST_CMD;
          else end_chunk();
        end
        ST_CMD: begin
          if (b[6]) begin
            r.event_kind = EV_VOLUME;
            r.value      = {b[5:0], 1'b0};
            if (b[7]) state = ST_CMD;
            else end_chunk();
          end else begin
            pend_cmd = b[5:0];
            state    = b[7] ? ST_PARAM_MORE : ST_PARAM_END;
          end
        end
        default: begin
          more = (state == ST_PARAM_MORE);
          c    = pend_cmd;
          if (c == CMD_PAN && b[7:4] == 4'h0) begin
            r.event_kind = EV_PAN;
            r.value      = b;
          end else if (c == CMD_VOLUME) begin
            r.event_kind = EV_VOLUME;
            r.value      = b;
          end else if (c == CMD_EXTENDED && b[7:4] == 4'hd) begin
            r.event_kind = EV_DELAY;
            r.value      = {4'h0, b[3:0]};
          end else begin
            r.command = c;
            r.value   = b;
            if (fx_count[chan] < EffectSlots) begin
              r.event_kind  = EV_EFFECT;
              r.effect_slot = fx_count[chan];
              fx_count[chan] = fx_count[chan] + 3'd1;
            end else begin
              r.event_kind = EV_DROPPED;
            end
            if (c == CMD_TONE_PORTA || c == CMD_PORTA_VOL || c == CMD_FINE_PORTA)
              r.portamento = 1'b1;
          end
          if (more) state = ST_CMD;
          else end_chunk();
        end
      endcase
      r.channel = (r.event_kind == EV_EMPTY_ROW) ? 5'd0 : chan;
      if (last) begin
        if (state != ST_HEAD) begin
          r.truncated = 1'b1;
          state       = ST_HEAD;
        end
        done = 1'b1;
      end
      if (row_pos >= row_count) done = 1'b1;
      r.pattern_done = (row_pos >= row_count);
      expected_events.push_back(r);
      return 1;
    endfunction

    function void check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        errors++;
      end
    endfunction

    function void check_event(logic [39:0] tdata);
      result_t exp;
      result_t got;
      got = result_t'(tdata[36:0]);
      if (expected_events.size() == 0) begin
        $error("event with no expectation pending: 0x%010h", tdata);
        errors++;
        return;
      end
      exp = expected_events.pop_front();
      check_field("event_kind",   exp.event_kind,   got.event_kind);
      check_field("channel",      exp.channel,      got.channel);
      check_field("row",          exp.row,          got.row);
      check_field("value",        exp.value,        got.value);
      check_field("command",      exp.command,      got.command);
      check_field("effect_slot",  exp.effect_slot,  got.effect_slot);
      check_field("portamento",   exp.portamento,   got.portamento);
      check_field("truncated",    exp.truncated,    got.truncated);
      check_field("pattern_done", exp.pattern_done, got.pattern_done);
      check_field("tdata_pad",    0,                tdata[39:37]);
    endfunction

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;
  logic        s_tlast   = 1'b0;
  logic        s_tuser   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = CFG_NOTE_OFFSET;
  logic [8:0]  cfg_data  = '0;

  pattern_event_scoreboard sb;
  int   result_items  = 0;     // bytes that produced an event
  int   sent_items    = 0;     // input transactions
  int   stall_cycles  = 0;
  bit   no_in_gap     = 1'b0;  // full-rate stretch on the input side
  bit   no_out_gap    = 1'b0;  // full-rate stretch on the output side
  bit   hold_off_req  = 1'b0;  // sink does one long stall when set
  logic [7:0] pat_bytes [$];   // bytes of the pattern being built

  tracker_pattern_chunk_decoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One input transaction: random gap, then hold the byte until accepted.
  task automatic send_byte(input logic [7:0] d, input logic l, input logic st);
    int gap;
    gap = no_in_gap ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= l;
    s_tuser  <= st;
    do @(posedge clk); while (!s_tready);
    sent_items++;
    if (sb.take_byte(d, l, st)) result_items++;
  endtask

  // Stop offering bytes and wait until the block has gone quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [8:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input logic [6:0] offset, input logic keyoff,
                           input logic [8:0] rows);
    settle();
    write_register(CFG_NOTE_OFFSET, {2'b00, offset});
    write_register(CFG_KEYOFF_ENABLE, {8'd0, keyoff});
    write_register(CFG_ROW_COUNT, rows);
    cfg_we <= 1'b0;
  endtask

  // Append one well-formed chunk to pat_bytes; returns rows it advances.
  function automatic int gen_chunk(int empty_pct);
    logic [7:0] head;
    logic [7:0] nb;
    logic [5:0] c;
    logic [7:0] p;
    logic       cmds_follow;
    logic       more;
    int         ncmd;
    if ($urandom_range(0, 99) < empty_pct) begin
      pat_bytes.push_back(8'hff);
      return 1;
    end
    // a few channels most of the time so effect slots run out
    head[4:0] = $urandom_range(0, 1) ? 5'($urandom_range(0, 3))
                                     : 5'($urandom_range(0, 31));
    head[7:5] = 3'($urandom_range(0, 7));
    pat_bytes.push_back(head);
    if (head == 8'hff) return 1;
    cmds_follow = head[6];
    if (!head[6]) begin
      case ($urandom_range(0, 7))
        0:       nb[6:0] = 7'd0;
        1:       nb[6:0] = 7'd1;
        2:       nb[6:0] = 7'd127;
        default: nb[6:0] = 7'($urandom_range(0, 127));
      endcase
      nb[7]       = 1'($urandom_range(0, 1));
      cmds_follow = nb[7];
      pat_bytes.push_back(nb);
      case ($urandom_range(0, 5))
        0:       pat_bytes.push_back(8'd0);
        1:       pat_bytes.push_back(8'hff);
        default: pat_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    if (cmds_follow) begin
      ncmd = $urandom_range(1, 6);
      for (int i = 0; i < ncmd; i++) begin
        more = (i != ncmd - 1);
        if ($urandom_range(0, 3) == 0) begin
          pat_bytes.push_back({more, 1'b1, 6'($urandom_range(0, 63))});
        end else begin
          case ($urandom_range(0, 7))
            0:       c = CMD_TONE_PORTA;
            1:       c = CMD_PORTA_VOL;
            2:       c = CMD_FINE_PORTA;
            3:       c = CMD_PAN;
            4:       c = CMD_VOLUME;
            5:       c = CMD_EXTENDED;
            default: c = 6'($urandom_range(0, 63));
          endcase
          pat_bytes.push_back({more, 1'b0, c});
          p = 8'($urandom_range(0, 255));
          // steer half the pan / extended params onto their special forms
          if ($urandom_range(0, 1)) begin
            if (c == CMD_PAN) p[7:4] = 4'h0;
            else if (c == CMD_EXTENDED) p[7:4] = 4'hd;
          end
          pat_bytes.push_back(p);
        end
      end
    end
    return int'(head[7]);
  endfunction

  // Build one pattern buffer and send it, start flag on the first byte.
  task automatic run_pattern(input int want_rows, input int empty_pct);
    int rows_made;
    int chunks;
    int end_idx;
    pat_bytes.delete();
    rows_made = 0;
    chunks    = 0;
    if ($urandom_range(0, 9) == 0) begin
      // noise buffer
      repeat ($urandom_range(3, 20)) pat_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      while (rows_made < want_rows && chunks < 400) begin
        rows_made += gen_chunk(empty_pct);
        chunks++;
      end
    end
    end_idx = pat_bytes.size() - 1;
    case ($urandom_range(0, 9))
      0, 1:    end_idx = $urandom_range(0, pat_bytes.size() - 1); // likely mid-chunk
      2:       end_idx = -1;  // no buffer end, next start cuts in
      default: ;
    endcase
    for (int i = 0; i < pat_bytes.size(); i++)
      send_byte(pat_bytes[i], i == end_idx, i == 0);
    // trailing bytes, ignored once the buffer has ended
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
  endtask

  task automatic run_phase(input logic [6:0] offset, input logic keyoff,
                           input logic [8:0] rows, input int empty_pct,
                           input int quota, input bit hold);
    int first;
    int want;
    configure(offset, keyoff, rows);
    no_in_gap    = ($urandom_range(0, 3) == 0);
    no_out_gap   = ($urandom_range(0, 3) == 0);
    hold_off_req = hold;
    first = result_items;
    while (result_items - first < quota) begin
      want = (rows == 9'd256) ? 257 : $urandom_range(1, rows + 1);
      run_pattern(want, empty_pct);
    end
  endtask

  // Sink: random ready gaps per transaction, one long stall on request.
  initial begin : event_sink
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HoldOffCycles;
      end else begin
        gap = no_out_gap ? 0 : $urandom_range(0, 7);
      end
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_event(m_tdata);
    end
  end

  // Watchdog: nothing moving on either stream for too long ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int phase;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed run at reset values: offset 24, key-off on, 64 rows.
    send_byte(8'hff, 1'b0, 1'b1); // empty row with pattern start
    send_byte(8'h1f, 1'b0, 1'b0); // head: channel 31, note follows
    send_byte(8'hff, 1'b0, 1'b0); // note 127, commands follow
    send_byte(8'hff, 1'b0, 1'b0); // instrument 255
    send_byte(8'hff, 1'b0, 1'b0); // volume/2 = 63, more
    send_byte(8'h88, 1'b0, 1'b0); // pan command
    send_byte(8'h0f, 1'b0, 1'b0); //   pan 15
    send_byte(8'h8c, 1'b0, 1'b0); // volume command
    send_byte(8'h40, 1'b0, 1'b0); //   volume 64
    send_byte(8'h8e, 1'b0, 1'b0); // extended command
    send_byte(8'hd5, 1'b0, 1'b0); //   delay note 5
    send_byte(8'h83, 1'b0, 1'b0); // tone portamento
    send_byte(8'h10, 1'b0, 1'b0); //   slot 0
    send_byte(8'h85, 1'b0, 1'b0); // portamento + volume slide
    send_byte(8'h00, 1'b0, 1'b0); //   slot 1
    send_byte(8'h95, 1'b0, 1'b0); // fine portamento
    send_byte(8'hff, 1'b0, 1'b0); //   slot 2
    send_byte(8'hbf, 1'b0, 1'b0); // command 63
    send_byte(8'h01, 1'b0, 1'b0); //   slot 3, last free slot
    send_byte(8'h01, 1'b0, 1'b0); // command 1, chunk ends after param
    send_byte(8'h02, 1'b0, 1'b0); //   dropped, slots used up
    send_byte(8'hc0, 1'b0, 1'b0); // head: last on row, no note, channel 0
    send_byte(8'h40, 1'b0, 1'b0); // volume 0, row advances
    send_byte(8'h00, 1'b0, 1'b0); // head: channel 0, note follows
    send_byte(8'h01, 1'b0, 1'b0); // key-off
    send_byte(8'h00, 1'b0, 1'b0); // no instrument
    send_byte(8'h05, 1'b0, 1'b0); // head: channel 5
    send_byte(8'h30, 1'b1, 1'b0); // buffer ends before the instrument byte
    send_byte(8'h00, 1'b0, 1'b0); // ignored, buffer has ended

    // Random phases: extremes first, then random settings.
    phase = 0;
    while (sent_items < 1100) begin
      case (phase)
        0: run_phase(7'd0, 1'b0, 9'd1, 10, 100, 1'b0);
        1: run_phase(7'd127, 1'b1, 9'd256, 90, 300, 1'b1);
        default: begin
          case ($urandom_range(0, 7))
            0:       run_phase(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                               9'd1, 15, 120, ($urandom_range(0, 2) == 0));
            1:       run_phase(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                               9'd64, 15, 120, ($urandom_range(0, 2) == 0));
            default: run_phase(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                               9'($urandom_range(2, 16)), 15, 120,
                               ($urandom_range(0, 2) == 0));
          endcase
        end
      endcase
      phase++;
    end

    settle();
    if (sb.pending() != 0) begin
      $error("%0d expected events never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[tracker_pattern_chunk_decoder_top.f]
src/tpcd_pkg.sv
src/tpcd_front.sv
src/tpcd_queue.sv
src/tpcd_back.sv
src/tracker_pattern_chunk_decoder_top.sv
sim/tracker_pattern_chunk_decoder_top_tb.sv
